### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the deadline timer queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define DTQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define DTQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/dtq_pkg.sv
// Package with the types, codes and constants of the deadline timer queue.
`default_nettype none
package dtq_pkg;

    localparam int DTQ_DEPTH = 16;
    localparam logic [15:0] WAIT_RESET = 16'd20;

    // Input item kinds.
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_EXPIRED = 3'd1;
    localparam logic [2:0] ST_ADDED   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_REMOVED = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    // Configuration register indexes.
    localparam logic [7:0] REG_WAIT_TIME = 8'd0;
    localparam logic [7:0] REG_KICK      = 8'd1;

    // Sequencer states.
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_SCAN = 8'b00000010,
        S_INS  = 8'b00000100,
        S_RMW  = 8'b00001000,
        S_TCHK = 8'b00010000,
        S_POP  = 8'b00100000,
        S_EMIT = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

endpackage
`default_nettype wire

### hw/rtl/dtq_sat_add.sv
// Deadline adder: current time plus wait time, saturated at the time maximum.
`default_nettype none
module dtq_sat_add
    import dtq_pkg::*;
(
    input  wire logic [31:0] i_now,
    input  wire logic [15:0] i_wait,
    output logic      [31:0] o_deadline
);

    logic [32:0] sum;

    // A carry out of the 32-bit sum clamps the deadline to all ones.
    assign sum = {1'b0, i_now} + {17'd0, i_wait};
    assign o_deadline = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

endmodule
`default_nettype wire

### hw/rtl/deadline_timeout_queue.sv
// Add: scan for the slot, then insert (a full table skips both); remove compacts; clear empties.
// A tick pops each expired entry (re-added unless kick is on); one comparator walks the table.
// Throughput: one item at a time; the next is taken once the last result is delivered.
// Reset (synchronous, active low) empties the table and restores wait time 20, kick off.
// Entry storage is not cleared; only entries below the count are ever read.
`default_nettype none
module deadline_timeout_queue
    import dtq_pkg::*;
#(
    parameter int DEPTH = DTQ_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata from bit 0: conn_id[15:0], sequence_req[31:0], now[31:0]
    input  wire logic [79:0] i_s_axis_tdata,
    // tuser: mode[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata from bit 0: expired_conn[15:0], expired_sequence[31:0],
    // entry_count[4:0], earliest_deadline[31:0], three zero bits
    output logic [87:0]      o_m_axis_tdata,
    // tuser: status[2:0]
    output logic [2:0]       o_m_axis_tuser,
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    `include "assert_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0] r_dl [DEPTH];
    logic [15:0] r_cn [DEPTH];
    logic [31:0] r_sq [DEPTH];

    t_state      r_state;
    logic [CW-1:0] r_cnt, r_idx, r_wp, r_budget;
    logic [31:0] r_key, r_now;
    logic [15:0] r_conn;
    logic [31:0] r_seq;
    logic [1:0]  r_op;
    logic        r_pend;
    logic [2:0]  r_est;
    logic        r_elast;
    logic [15:0] r_wait;
    logic        r_kick;

    logic        r_ov, r_olast;
    logic [2:0]  r_ostat;
    logic [15:0] r_oconn;
    logic [31:0] r_oseq, r_ohead;
    logic [CW-1:0] r_ocnt;

    logic [31:0] deadline;
    logic        in_acc, scan_go, tick_go;

    dtq_sat_add u_sat_add (
        .i_now      (i_s_axis_tdata[79:48]),
        .i_wait     (r_wait),
        .o_deadline (deadline)
    );

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    // The comparator that walks the table: a table entry against the key deadline.
    assign scan_go = (r_idx < r_cnt) && (r_dl[r_idx[AW-1:0]] <= r_key);
    assign tick_go = (r_budget != '0) && (r_cnt != '0) && (r_dl[0] <= r_now);

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= WAIT_RESET;
            r_kick <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WAIT_TIME) begin
                r_wait <= i_cfg_data;
            end else if (i_cfg_index == REG_KICK) begin
                r_kick <= i_cfg_data[0];
            end
        end
    end

    // Sequencer with the table and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op   <= i_s_axis_tuser;
                        r_conn <= i_s_axis_tdata[15:0];
                        r_seq  <= i_s_axis_tdata[47:16];
                        r_now  <= i_s_axis_tdata[79:48];
                        r_key  <= deadline;
                        r_idx  <= '0;
                        r_wp   <= '0;
                        r_elast <= 1'b1;
                        unique case (i_s_axis_tuser)
                            MODE_ADD: begin
                                if (r_cnt >= CW'(DEPTH)) begin
                                    r_est   <= ST_FULL;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            MODE_REMOVE: r_state <= S_RMW;
                            MODE_CLEAR: begin
                                r_cnt   <= '0;
                                r_est   <= ST_CLEARED;
                                r_state <= S_EMIT;
                            end
                            default: begin
                                r_budget <= r_cnt;
                                r_pend   <= 1'b0;
                                r_state  <= S_TCHK;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_go) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    // Open a slot at the found position and store the entry.
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CW'(i) > r_idx) begin
                            r_dl[i] <= r_dl[(i > 0) ? i - 1 : 0];
                            r_cn[i] <= r_cn[(i > 0) ? i - 1 : 0];
                            r_sq[i] <= r_sq[(i > 0) ? i - 1 : 0];
                        end else if (CW'(i) == r_idx) begin
                            r_dl[i] <= r_key;
                            r_cn[i] <= r_conn;
                            r_sq[i] <= r_seq;
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_op == MODE_ADD) begin
                        r_est   <= ST_ADDED;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_TCHK;
                    end
                end
                S_RMW: begin
                    // Compact the table, keeping entries of other connections.
                    if (r_idx < r_cnt) begin
                        if (r_cn[r_idx[AW-1:0]] != r_conn) begin
                            r_dl[r_wp[AW-1:0]] <= r_dl[r_idx[AW-1:0]];
                            r_cn[r_wp[AW-1:0]] <= r_cn[r_idx[AW-1:0]];
                            r_sq[r_wp[AW-1:0]] <= r_sq[r_idx[AW-1:0]];
                            r_wp <= r_wp + 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_cnt   <= r_wp;
                        r_est   <= ST_REMOVED;
                        r_state <= S_EMIT;
                    end
                end
                S_TCHK: begin
                    // A pending expiry is shown once it is known whether another follows.
                    if (r_pend) begin
                        r_est   <= ST_EXPIRED;
                        r_elast <= !tick_go;
                        r_state <= S_EMIT;
                    end else if (tick_go) begin
                        r_state <= S_POP;
                    end else begin
                        r_est   <= ST_NONE;
                        r_elast <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_POP: begin
                    r_conn <= r_cn[0];
                    r_seq  <= r_sq[0];
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        r_dl[i] <= r_dl[i + 1];
                        r_cn[i] <= r_cn[i + 1];
                        r_sq[i] <= r_sq[i + 1];
                    end
                    r_cnt    <= r_cnt - 1'b1;
                    r_budget <= r_budget - 1'b1;
                    r_pend   <= 1'b1;
                    r_idx    <= '0;
                    r_state  <= r_kick ? S_TCHK : S_SCAN;
                end
                S_EMIT: begin
                    r_ov    <= 1'b1;
                    r_ostat <= r_est;
                    r_olast <= r_elast;
                    r_oconn <= (r_est == ST_EXPIRED) ? r_conn : 16'd0;
                    r_oseq  <= (r_est == ST_EXPIRED) ? r_seq : 32'd0;
                    r_ocnt  <= r_cnt;
                    r_ohead <= (r_cnt != '0) ? r_dl[0] : 32'd0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_axis_tready) begin
                        r_ov    <= 1'b0;
                        r_pend  <= 1'b0;
                        r_state <= r_olast ? S_IDLE : S_TCHK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tuser  = r_ostat;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tdata  = {3'd0, r_ohead, 5'(r_ocnt), r_oseq, r_oconn};

    `DTQ_ASSERT(a_cnt_bound, r_cnt <= CW'(DEPTH), "entry count above table depth")
    `DTQ_ASSERT(a_busy_out, o_m_axis_tvalid |-> !o_s_axis_tready, "input taken while result waits")
    `DTQ_ASSERT(a_added_nonempty, (o_m_axis_tvalid && r_ostat == ST_ADDED) |-> (r_ocnt != '0),
                "add result reports an empty table")
    `DTQ_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !r_ov),
                       "sequencer not idle after reset")

endmodule
`default_nettype wire

### tb/deadline_timeout_queue_test.sv
// Self-checking testbench for the sorted deadline timer queue with its own table predictor.
`default_nettype none
module deadline_timeout_queue_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dtq_pkg::*;

    localparam int DEPTH = DTQ_DEPTH;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] conn;
        logic [31:0] seq;
        logic [31:0] now;
    } t_timer_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] conn;
        logic [31:0] seq;
        logic [4:0]  count;
        logic [31:0] head;
        logic        last;
    } t_timer_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [79:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    wire         s_ready;
    wire         m_valid;
    wire  [87:0] m_data;
    wire  [2:0]  m_user;
    wire         m_last;
    wire         cfg_ready;

    deadline_timeout_queue dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user), .o_m_axis_tlast(m_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted table state and configuration.
    logic [31:0] tbl_deadline [DEPTH];
    logic [15:0] tbl_conn [DEPTH];
    logic [31:0] tbl_seq [DEPTH];
    int          tbl_count = 0;
    logic [15:0] wait_secs = WAIT_RESET;
    logic        kick_mode = 1'b0;

    t_timer_cmd   pending_cmds[$];
    t_timer_event expected_events[$];
    int  fail_count = 0;
    int  send_idle_pct = 38;
    int  recv_idle_pct = 62;
    int  idle_cycles = 0;
    bit  hold_sender = 1'b0;
    bit  in_taken = 1'b0;

    function automatic logic [31:0] deadline_from(logic [31:0] now);
        logic [32:0] sum;
        sum = {1'b0, now} + {17'd0, wait_secs};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic void table_insert(logic [31:0] d, logic [15:0] c, logic [31:0] s);
        int pos;
        pos = 0;
        while (pos < tbl_count && tbl_deadline[pos] <= d) pos++;
        for (int i = tbl_count; i > pos; i--) begin
            tbl_deadline[i] = tbl_deadline[i-1];
            tbl_conn[i] = tbl_conn[i-1];
            tbl_seq[i] = tbl_seq[i-1];
        end
        tbl_deadline[pos] = d;
        tbl_conn[pos] = c;
        tbl_seq[pos] = s;
        tbl_count++;
    endfunction

    function automatic void push_event(logic [2:0] st, logic [15:0] c, logic [31:0] s);
        t_timer_event ev;
        ev.status = st;
        ev.conn = c;
        ev.seq = s;
        ev.count = tbl_count[4:0];
        ev.head = tbl_count > 0 ? tbl_deadline[0] : 32'd0;
        ev.last = 1'b0;
        expected_events.insert(expected_events.size(), ev);
    endfunction

    // Applies one command to the predicted table and queues its results.
    function automatic void predict_timer_cmd(t_timer_cmd cmd);
        int budget;
        int w;
        int first_idx;
        logic [15:0] c;
        logic [31:0] s;
        first_idx = expected_events.size();
        case (cmd.mode)
            MODE_ADD: begin
                if (tbl_count >= DEPTH) begin
                    push_event(ST_FULL, '0, '0);
                end else begin
                    table_insert(deadline_from(cmd.now), cmd.conn, cmd.seq);
                    push_event(ST_ADDED, '0, '0);
                end
            end
            MODE_REMOVE: begin
                w = 0;
                for (int r = 0; r < tbl_count; r++) begin
                    if (tbl_conn[r] != cmd.conn) begin
                        tbl_deadline[w] = tbl_deadline[r];
                        tbl_conn[w] = tbl_conn[r];
                        tbl_seq[w] = tbl_seq[r];
                        w++;
                    end
                end
                tbl_count = w;
                push_event(ST_REMOVED, '0, '0);
            end
            MODE_CLEAR: begin
                tbl_count = 0;
                push_event(ST_CLEARED, '0, '0);
            end
            default: begin
                budget = tbl_count;
                while (budget > 0 && tbl_count > 0 && tbl_deadline[0] <= cmd.now) begin
                    c = tbl_conn[0];
                    s = tbl_seq[0];
                    for (int i = 0; i + 1 < tbl_count; i++) begin
                        tbl_deadline[i] = tbl_deadline[i+1];
                        tbl_conn[i] = tbl_conn[i+1];
                        tbl_seq[i] = tbl_seq[i+1];
                    end
                    tbl_count--;
                    if (!kick_mode) table_insert(deadline_from(cmd.now), c, s);
                    push_event(ST_EXPIRED, c, s);
                    budget--;
                end
                if (expected_events.size() == first_idx) push_event(ST_NONE, '0, '0);
            end
        endcase
        expected_events[expected_events.size()-1].last = 1'b1;
    endfunction

    // Input driver: presents queued commands at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            s_valid <= 1'b1;
        end else if (pending_cmds.size() > 0 &&
                     !(hold_sender && expected_events.size() > 0) &&
                     $urandom_range(99, 0) >= send_idle_pct) begin
            s_valid <= 1'b1;
            s_user <= pending_cmds[0].mode;
            s_data <= {pending_cmds[0].now, pending_cmds[0].seq, pending_cmds[0].conn};
            pending_cmds.delete(0);
        end else begin
            s_valid <= 1'b0;
        end
        m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Monitor: predicts on accepted commands and checks each result transaction.
    always @(posedge i_clk) begin
        t_timer_cmd   cmd;
        t_timer_event got;
        t_timer_event exp_ev;
        in_taken <= i_rst_n && s_valid && s_ready;
        if (i_rst_n) begin
            if (s_valid && s_ready) begin
                cmd.mode = s_user;
                {cmd.now, cmd.seq, cmd.conn} = s_data;
                predict_timer_cmd(cmd);
            end
            if (m_valid && m_ready) begin
                got.status = m_user;
                got.conn = m_data[15:0];
                got.seq = m_data[47:16];
                got.count = m_data[52:48];
                got.head = m_data[84:53];
                got.last = m_last;
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count++;
                end else begin
                    exp_ev = expected_events[0];
                    expected_events.delete(0);
                    if (got !== exp_ev) begin
                        $display("%0t: mismatch, expected st=%0d conn=%h seq=%h cnt=%0d head=%h last=%b",
                                 $time, exp_ev.status, exp_ev.conn, exp_ev.seq, exp_ev.count,
                                 exp_ev.head, exp_ev.last);
                        $display("%0t:          actual st=%0d conn=%h seq=%h cnt=%0d head=%h last=%b",
                                 $time, got.status, got.conn, got.seq, got.count,
                                 got.head, got.last);
                        fail_count++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_cmd(logic [1:0] mode, logic [15:0] conn, logic [31:0] seq,
                             logic [31:0] now);
        t_timer_cmd cmd;
        cmd.mode = mode;
        cmd.conn = conn;
        cmd.seq = seq;
        cmd.now = now;
        pending_cmds.insert(pending_cmds.size(), cmd);
    endtask

    task automatic drain_all();
        while (pending_cmds.size() > 0 || s_valid || expected_events.size() > 0)
            @(posedge i_clk);
        repeat (DEPTH * (DEPTH + 8)) @(posedge i_clk);
    endtask

    // Register write through the configuration channel while the queue is idle.
    task automatic write_reg(logic [7:0] idx, logic [15:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        if (idx == REG_WAIT_TIME) wait_secs = value;
        else if (idx == REG_KICK) kick_mode = value[0];
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // One burst of random commands around a moving clock with a small set of connections.
    task automatic random_burst(int n);
        logic [31:0] t;
        int pick;
        t = $urandom_range(1000, 0);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99, 0);
            t = t + $urandom_range(8, 0);
            if (pick < 50)
                queue_cmd(MODE_ADD, (pick < 45) ? 16'($urandom_range(7, 0)) : 16'($urandom),
                          $urandom, ($urandom_range(19, 0) == 0) ? $urandom : t);
            else if (pick < 60)
                queue_cmd(MODE_REMOVE, 16'($urandom_range(7, 0)), $urandom, $urandom);
            else if (pick < 63)
                queue_cmd(MODE_CLEAR, 16'($urandom), $urandom, $urandom);
            else
                queue_cmd(MODE_TICK, 16'($urandom), $urandom,
                          ($urandom_range(19, 0) == 0) ? $urandom : t + $urandom_range(40, 0));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every command kind, full table, empty-table cases.
        queue_cmd(MODE_TICK, 16'h0000, 32'h0, 32'hFFFF_FFFF);
        queue_cmd(MODE_REMOVE, 16'hFFFF, 32'h0, 32'h0);
        queue_cmd(MODE_CLEAR, 16'h0, 32'h0, 32'h0);
        queue_cmd(MODE_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        queue_cmd(MODE_ADD, 16'h0000, 32'h0000_0000, 32'd0);
        for (int i = 0; i < DEPTH - 1; i++)
            queue_cmd(MODE_ADD, 16'(i + 1), 32'hA5A5_0000 + i, 32'd10);
        queue_cmd(MODE_REMOVE, 16'h1234, 32'h0, 32'h0);
        queue_cmd(MODE_TICK, 16'h0, 32'h0, 32'd30);
        queue_cmd(MODE_REMOVE, 16'd3, 32'h0, 32'h0);
        queue_cmd(MODE_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);
        drain_all();

        // Extreme settings: zero wait time keeps deadlines at now; saturation.
        write_reg(REG_WAIT_TIME, 16'd0);
        queue_cmd(MODE_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);
        queue_cmd(MODE_ADD, 16'h5A5A, 32'h1, 32'd100);
        drain_all();
        write_reg(REG_WAIT_TIME, 16'hFFFF);
        write_reg(REG_KICK, 16'd1);
        write_reg(8'd2, 16'hFFFF);
        queue_cmd(MODE_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);
        queue_cmd(MODE_ADD, 16'h0F0F, 32'h2, 32'hFFFF_0000);
        drain_all();

        // Random phases with idling patterns and settings.
        write_reg(REG_WAIT_TIME, 16'd1);
        write_reg(REG_KICK, 16'd0);
        random_burst(25);
        drain_all();

        send_idle_pct = 62;
        recv_idle_pct = 38;
        write_reg(REG_WAIT_TIME, 16'($urandom_range(30, 2)));
        write_reg(REG_KICK, 16'd1);
        random_burst(25);
        drain_all();

        // Sender waits for every result before the next command.
        hold_sender = 1'b1;
        random_burst(5);
        drain_all();
        hold_sender = 1'b0;

        // Last burst at full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_WAIT_TIME, 16'd20);
        write_reg(REG_KICK, 16'd0);
        random_burst(25);
        drain_all();

        if (fail_count == 0 && expected_events.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_sat_add.sv
hw/rtl/deadline_timeout_queue.sv
tb/deadline_timeout_queue_test.sv
